@@ sv/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// next-cycle implication, disabled while reset is active
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

@@ sv/mhic_pkg.sv @@
// shared types and constants for the magnetometer hard-iron calibrator
// no dependencies
package mhic_pkg;

    localparam int AXES     = 3;
    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int GAIN_W   = 16;
    localparam int FIELD_W  = 33;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 152;
    localparam int USER_W   = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [FIELD_W-1:0]  field_t;
    typedef logic        [GAIN_W-1:0]   gain_t;

    localparam gain_t   GAIN_RESET    = 16'd384;
    localparam sample_t AXIS_MAX_INIT = 16'sh8000;
    localparam sample_t AXIS_MIN_INIT = 16'sh7fff;
    localparam sample_t OFFSET_INIT   = 16'sh0000;

    // per-axis tracker status for the current sample
    typedef struct packed {
        sample_t offset;
        logic    valid;
        logic    upd;
    } trk_stat_t;

endpackage

@@ sv/mhic_axis_track.sv @@
// per-axis running min/max tracker and midpoint offset
// depends on mhic_pkg
module mhic_axis_track
    import mhic_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  sample_t   sample,
    output trk_stat_t stat
);

    sample_t max_reg, max_next;
    sample_t min_reg, min_next;
    sample_t offset_reg, offset_next;
    logic    valid_reg, valid_next;
    logic    gt, lt, upd;
    diff_t   sum;
    sample_t mid;

    always_comb
    begin
        gt       = sample > max_reg;
        lt       = sample < min_reg;
        upd      = gt | lt;
        max_next = gt ? sample : max_reg;
        min_next = lt ? sample : min_reg;
        sum      = diff_t'(min_next) + diff_t'(max_next);
        mid      = sum[DIFF_W-1:1];
        offset_next = upd ? mid : offset_reg;
        valid_next  = upd ? (max_next != mid) : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= AXIS_MAX_INIT;
            min_reg    <= AXIS_MIN_INIT;
            offset_reg <= OFFSET_INIT;
            valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            max_reg    <= max_next;
            min_reg    <= min_next;
            offset_reg <= offset_next;
            valid_reg  <= valid_next;
        end
    end

    assign stat.offset = offset_next;
    assign stat.valid  = valid_next;
    assign stat.upd    = upd;

endmodule

@@ sv/mhic_scale.sv @@
// registered signed difference times unsigned gain
// depends on mhic_pkg
module mhic_scale
    import mhic_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  diff_t  diff,
    input  gain_t  gain,
    output field_t prod
);

    field_t prod_reg;
    field_t prod_next;

    always_comb
    begin
        prod_next = field_t'(diff) * $signed({{(FIELD_W-GAIN_W){1'b0}}, gain});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ sv/mag_hard_iron_calibrator.sv @@
// top level of the magnetometer hard-iron calibrator
// depends on mhic_pkg, mhic_axis_track, mhic_scale
//
// s_tdata carries one raw sample per transfer, six bytes of sensor x, y, z.
// the sample is remapped to body axes (x = sensor y, y = -sensor x,
// z = -sensor z), the per-axis min/max and midpoint offsets are updated,
// and m_tdata returns (axis - offset) * gain with 8 fractional bits plus
// the current offsets; m_tuser carries the all-valid and recal-due flags.
// cfg_data writes the sensitivity gain; cfg_ready is always high and a
// write must only be issued while no sample is in flight.
// three register stages: input, tracker update, multiply into the output
// register. one sample per cycle is sustained while m_tready stays high;
// the tracker compare and midpoint add set the path of the middle stage,
// the 17x16 multiply that of the last.
// when m_tready is low the stages fill up behind the output register and
// s_tready drops only once all three hold a sample.
// reset clears the stage and tracker valid flags, sets the gain to 1.5 and returns the
// trackers to their empty state.
module mag_hard_iron_calibrator
    import mhic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // x_low, x_high, y_low, y_high, z_low, z_high
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // field_x, field_y, field_z, offset_x, offset_y, offset_z, zero pad
    output logic [OUT_W-1:0]  m_tdata,
    // all_offsets_valid, recal_due
    output logic [USER_W-1:0] m_tuser,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GAIN_W-1:0] cfg_data
);

    gain_t     gain_reg;
    logic      a_valid_reg, b_valid_reg, c_valid_reg;
    logic      a_ready, b_ready, c_ready;
    logic      a_adv, b_adv;
    sample_t   body_reg [AXES];
    sample_t   body_next [AXES];
    diff_t     diff_reg [AXES];
    sample_t   off_b_reg [AXES];
    sample_t   off_c_reg [AXES];
    logic      allv_b_reg, recal_b_reg, allv_c_reg, recal_c_reg;
    trk_stat_t stat [AXES];
    field_t    prod [AXES];
    logic      all_valid, any_upd;
    sample_t   sx, sy, sz;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            gain_reg <= cfg_data;
        end
    end

    assign c_ready  = !c_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign b_adv    = b_valid_reg && c_ready;
    assign a_adv    = a_valid_reg && b_ready;
    assign s_tready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // byte assembly and body-axis remap
    always_comb
    begin
        sx = {s_tdata[15:8], s_tdata[7:0]};
        sy = {s_tdata[31:24], s_tdata[23:16]};
        sz = {s_tdata[47:40], s_tdata[39:32]};
        body_next[0] = sy;
        body_next[1] = -sx;
        body_next[2] = -sz;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && a_ready)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                body_reg[i] <= body_next[i];
            end
        end
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_axis
        mhic_axis_track u_track (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (a_adv),
            .sample (body_reg[g]),
            .stat   (stat[g])
        );

        mhic_scale u_scale (
            .clk  (clk),
            .en   (b_adv),
            .diff (diff_reg[g]),
            .gain (gain_reg),
            .prod (prod[g])
        );
    end

    always_comb
    begin
        all_valid = stat[0].valid & stat[1].valid & stat[2].valid;
        any_upd   = stat[0].upd | stat[1].upd | stat[2].upd;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                diff_reg[i]  <= diff_t'(body_reg[i]) - diff_t'(stat[i].offset);
                off_b_reg[i] <= stat[i].offset;
            end
            allv_b_reg  <= all_valid;
            recal_b_reg <= any_upd & all_valid;
        end
        if (b_adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                off_c_reg[i] <= off_b_reg[i];
            end
            allv_c_reg  <= allv_b_reg;
            recal_c_reg <= recal_b_reg;
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {5'b0, off_c_reg[2], off_c_reg[1], off_c_reg[0],
                       prod[2], prod[1], prod[0]};
    assign m_tuser  = {recal_c_reg, allv_c_reg};

endmodule

@@ sv/mhic_checker.sv @@
// port-level checks for the magnetometer hard-iron calibrator
// depends on mhic_pkg and assert_macros.svh, bound to mag_hard_iron_calibrator
`include "assert_macros.svh"

module mhic_checker
    import mhic_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic [USER_W-1:0] m_tuser
);

    // stalled output transfer holds its payload
    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
              m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // recalibration is only flagged with every axis valid
    `CHK_IMPLY(a_recal_valid, clk, rst_n, m_tvalid && m_tuser[1], m_tuser[0])

    // pad bits above the offsets stay zero
    `CHK_IMPLY(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_W-1:147] == '0)

    // input backpressure only when the output register is full
    `CHK_IMPLY(a_stall_full, clk, rst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind mag_hard_iron_calibrator mhic_checker u_mhic_checker (.*);

@@ verif/tb_top.sv @@
// self-checking testbench for mag_hard_iron_calibrator
// depends on mhic_pkg and the calibrator rtl; a built-in tracker model predicts all outputs but those of typed rows
// directed table first, then randomized samples under several gain settings with random stalls
module tb_top;
    import mhic_pkg::*;

    localparam int DIR_ROWS    = 12;
    localparam int PHASES      = 6;
    localparam int RAND_ITEMS  = 950;
    localparam int NOISE_START = RAND_ITEMS - RAND_ITEMS / 10;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        field_t  [AXES-1:0] fld;
        sample_t [AXES-1:0] ofs;
        logic               all_ok;
        logic               recal;
    } calib_result_t;

    typedef struct packed {
        logic [IN_W-1:0] raw;
        logic            typed;
        calib_result_t   res;
    } dir_row_t;

    // raw is {z_high, z_low, y_high, y_low, x_high, x_low}
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{48'h0000_0000_0000, 1'b1, '0},
        '{48'h0000_0000_0000, 1'b1, '0},
        '{48'hffff_0001_ffff, 1'b1,
          {{3{field_t'(384)}}, {3{sample_t'(0)}}, 1'b1, 1'b1}},
        '{48'hffff_0001_ffff, 1'b1,
          {{3{field_t'(384)}}, {3{sample_t'(0)}}, 1'b1, 1'b0}},
        '{48'h8000_8000_8000, 1'b1,
          {{3{field_t'(-6291456)}}, {3{sample_t'(-16384)}}, 1'b1, 1'b1}},
        '{48'h7fff_0080_7fff, 1'b0, '0},
        '{48'hff00_ff00_00ff, 1'b0, '0},
        '{48'h0101_0101_ff7f, 1'b0, '0},
        '{48'hfe00_0200_fe00, 1'b0, '0},
        '{48'hfdff_0201_fdff, 1'b0, '0},
        '{48'h0000_0000_0000, 1'b0, '0},
        '{48'hfdff_0201_fdff, 1'b0, '0}
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_data  = '0;

    sample_t          trk_max [AXES] = '{AXIS_MAX_INIT, AXIS_MAX_INIT, AXIS_MAX_INIT};
    sample_t          trk_min [AXES] = '{AXIS_MIN_INIT, AXIS_MIN_INIT, AXIS_MIN_INIT};
    sample_t          trk_ofs [AXES] = '{OFFSET_INIT, OFFSET_INIT, OFFSET_INIT};
    logic [AXES-1:0]  trk_ok         = '0;
    gain_t            cur_gain       = GAIN_RESET;

    calib_result_t    pending_results [$];
    calib_result_t    want_res;
    calib_result_t    got_res;
    string            axis_name [AXES] = '{"x", "y", "z"};
    gain_t            phase_gain [PHASES];

    int               mismatches   = 0;
    int               samples_sent = 0;
    int               results_seen = 0;
    int               recal_seen   = 0;
    int               gains_set    = 0;
    int               quiet_cycles = 0;
    bit               src_calm     = 1'b0;
    bit               snk_calm     = 1'b0;

    mag_hard_iron_calibrator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle cycles before the next transfer, with stretches of none
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    // updates the min/max trackers and returns the output for one sample
    function automatic calib_result_t predict_calibration(input logic [IN_W-1:0] raw);
        sample_t       body [AXES];
        diff_t         sum;
        diff_t         d;
        logic          upd;
        logic          moved;
        calib_result_t r;
        body[0] = raw[31:16];
        body[1] = -sample_t'(raw[15:0]);
        body[2] = -sample_t'(raw[47:32]);
        moved = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            upd = 1'b0;
            if (body[i] > trk_max[i])
            begin
                trk_max[i] = body[i];
                upd = 1'b1;
            end
            if (body[i] < trk_min[i])
            begin
                trk_min[i] = body[i];
                upd = 1'b1;
            end
            if (upd)
            begin
                sum = diff_t'(trk_min[i]) + diff_t'(trk_max[i]);
                trk_ofs[i] = sample_t'(sum >>> 1);
                trk_ok[i] = (trk_max[i] != trk_ofs[i]);
                moved = 1'b1;
            end
        end
        r.all_ok = &trk_ok;
        r.recal = moved && r.all_ok;
        for (int i = 0; i < AXES; i++)
        begin
            d = diff_t'(body[i]) - diff_t'(trk_ofs[i]);
            r.fld[i] = field_t'(d) * field_t'($signed({1'b0, cur_gain}));
            r.ofs[i] = trk_ofs[i];
        end
        return r;
    endfunction

    // slow maximum growth so offsets keep moving, in-range and repeats; random when noisy
    function automatic logic [IN_W-1:0] draw_sample(input bit noisy);
        sample_t body [AXES];
        sample_t sx;
        sample_t sz;
        int      pick;
        int      top;
        if (noisy)
            return IN_W'({$urandom, $urandom});
        for (int i = 0; i < AXES; i++)
        begin
            pick = int'($urandom_range(0, 9));
            if (pick < 5)
            begin
                top = int'(trk_max[i]) + int'($urandom_range(0, 150));
                if (top > 32767)
                    top = 32767;
                body[i] = sample_t'(top);
            end
            else if (pick < 8)
                body[i] = sample_t'(int'(trk_min[i]) +
                          int'($urandom_range(0, int'(trk_max[i]) - int'(trk_min[i]))));
            else
                body[i] = (pick == 8) ? trk_max[i] : trk_min[i];
        end
        sx = -body[1];
        sz = -body[2];
        return {sz, body[0], sx};
    endfunction

    task automatic push_sample(input logic [IN_W-1:0] raw, input logic typed,
                               input calib_result_t typed_res);
        int            gap;
        calib_result_t predicted;
        gap = draw_gap(src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_calibration(raw);
        pending_results.push_back(typed ? typed_res : predicted);
        samples_sent++;
    endtask

    task automatic write_gain(input gain_t g);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_gain = g;
        gains_set++;
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic signed [63:0] want,
                                   input logic signed [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch on %s, result %0d: expected %0d, got %0d",
                     what, results_seen, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            for (int i = 0; i < AXES; i++)
            begin
                got_res.fld[i] = m_tdata[i*FIELD_W +: FIELD_W];
                got_res.ofs[i] = m_tdata[AXES*FIELD_W + i*SAMPLE_W +: SAMPLE_W];
            end
            got_res.all_ok = m_tuser[0];
            got_res.recal  = m_tuser[1];
            if (got_res.recal === 1'b1)
                recal_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d arrived with no sample pending", results_seen);
            end
            else
            begin
                want_res = pending_results.pop_front();
                for (int i = 0; i < AXES; i++)
                begin
                    if (got_res.fld[i] !== want_res.fld[i])
                        report_mismatch({"field_", axis_name[i]},
                                        $signed(want_res.fld[i]), $signed(got_res.fld[i]));
                    if (got_res.ofs[i] !== want_res.ofs[i])
                        report_mismatch({"offset_", axis_name[i]},
                                        $signed(want_res.ofs[i]), $signed(got_res.ofs[i]));
                end
                if (got_res.all_ok !== want_res.all_ok)
                    report_mismatch("all_offsets_valid", want_res.all_ok, got_res.all_ok);
                if (got_res.recal !== want_res.recal)
                    report_mismatch("recal_due", want_res.recal, got_res.recal);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending_results.size());
            $display("tb_top: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // output side back-pressure
    initial
    begin : sink
        int hold;
        wait (rst_n);
        forever
        begin
            hold = draw_gap(snk_calm);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : stim
        int per_phase;
        int idx;
        int cnt;
        phase_gain[0] = 16'hffff;
        phase_gain[1] = 16'h0000;
        phase_gain[2] = 16'h0001;
        phase_gain[3] = gain_t'($urandom_range(0, 65535));
        phase_gain[4] = 16'h0100;
        phase_gain[5] = gain_t'($urandom_range(0, 65535));
        per_phase = RAND_ITEMS / PHASES;
        idx = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run at the reset gain
        for (int r = 0; r < DIR_ROWS; r++)
            push_sample(dir_rows[r].raw, dir_rows[r].typed, dir_rows[r].res);

        for (int p = 0; p < PHASES; p++)
        begin
            write_gain(phase_gain[p]);
            cnt = (p == PHASES - 1) ? RAND_ITEMS - idx : per_phase;
            for (int n = 0; n < cnt; n++)
            begin
                push_sample(draw_sample(idx >= NOISE_START), 1'b0, '0);
                idx++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d samples and %0d checked results over %0d gain settings",
                 samples_sent, results_seen, gains_set + 1);
        $display("recalibration flagged on %0d results, %0d mismatches counted",
                 recal_seen, mismatches);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/mhic_pkg.sv
sv/mhic_axis_track.sv
sv/mhic_scale.sv
sv/mag_hard_iron_calibrator.sv
sv/mhic_checker.sv
verif/tb_top.sv
